// ----- rtl/xpg_pkg.sv -----
package xpg_pkg;

   // ln2 rounded to 64 fraction bits
   localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;
   localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
   localparam int unsigned LOG_FRAC = 56;
   localparam int unsigned SEED_REGS = 4;

   localparam logic CMD_RAW = 1'b0;
   localparam logic CMD_GAUSS = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic load_req;
      logic draw;
      logic take_x;
      logic take_y;
      logic ax2_start;
      logic ax2_step;
      logic ay2_step;
      logic form_r;
      logic norm_step;
      logic log_init;
      logic log_step;
      logic mul_start;
      logic mul_step;
      logic div_init;
      logic div_step;
      logic neg_form;
      logic z2_take;
      logic sqrt_init;
      logic sqrt_step;
      logic finish_raw;
      logic finish_gauss;
      logic finish_giveup;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic cmd;
      logic accept_pair;
      logic norm_done;
      logic mul_done;
   } dp_status_type;

endpackage

// ----- rtl/xpg_datapath.sv -----
module xpg_datapath #(
   parameter int NUM_STREAMS = 4,
   parameter int OUT_FRAC_BITS = 26,
   parameter int MAX_TRIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_data,
   input  logic                req_cmd,
   input  logic [1:0]          req_stream,
   input  xpg_pkg::dp_cmd_type cmd_in,
   input  logic [6:0]          tries_in,
   output xpg_pkg::dp_status_type status,
   output logic [63:0]         raw_value,
   output logic [31:0]         gauss_value,
   output logic [6:0]          tries,
   output logic                gave_up
);

   localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
   localparam int Z2_SHIFT = 118 - 2 * OUT_FRAC_BITS;

   logic [63:0] state_ff [NUM_STREAMS];
   logic [SW-1:0] sel_ff;
   logic cmd_ff;
   logic [63:0] draw_v;
   logic [63:0] draw_ff;
   logic [31:0] ax_ff, ay_ff;
   logic x_neg_ff;
   logic [63:0] ax2_ff, acc_ff, r_ff, m_ff, frac_ff, c_ff, rem_ff, lval_ff;
   logic [6:0] e_ff;
   logic [63:0] ma_ff, mb_ff;
   logic [127:0] prod_ff;
   logic [5:0] mcnt_ff;
   logic [63:0] sq_v_ff, sq_res_ff, sq_bit_ff, z2_ff;
   logic [63:0] raw_ff;
   logic [31:0] gauss_ff;
   logic [6:0] tries_ff;
   logic gave_up_ff;

   logic [SW-1:0] req_sel;
   logic [3:0] stream_red;
   logic [63:0] cur, nxt;
   logic [31:0] u;
   logic [31:0] absv;
   logic [127:0] sq;

   // reduce stream index modulo the stream count
   always_comb begin
      stream_red = {2'b00, req_stream};
      for (int k = 0; k < 3; k++) begin
         if (stream_red >= 4'(NUM_STREAMS)) stream_red = stream_red - 4'(NUM_STREAMS);
      end
      req_sel = SW'(stream_red);
   end

   // xorshift step of the selected stream
   always_comb begin
      cur = state_ff[sel_ff];
      nxt = cur ^ (cur << 21);
      nxt = nxt ^ (nxt >> 35);
      nxt = nxt ^ (nxt << 4);
      draw_v = nxt;
      u = nxt[63:32];
      absv = u[31] ? (u - 32'h80000000) : (32'h80000000 - u);
   end

   // stream states
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STREAMS; i++) state_ff[i] <= 64'(i + 1);
      end else if (csr_write) begin
         if (32'(csr_index) < NUM_STREAMS) state_ff[SW'(csr_index)] <= csr_data;
      end else if (cmd_in.draw) begin
         state_ff[sel_ff] <= nxt;
      end
   end

   // shared 64x64 multiplier: one 32x32 partial product a cycle
   logic [31:0] pa, pb;
   logic [63:0] pp;
   always_comb begin
      pa = mcnt_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
      pb = mcnt_ff[1] ? mb_ff[63:32] : mb_ff[31:0];
      pp = pa * pb;
      sq = {64'd0, pp} << (32 * (32'(mcnt_ff[0]) + 32'(mcnt_ff[1])));
   end

   logic [63:0] sq_sum;
   always_comb begin
      sq_sum = sq_res_ff + sq_bit_ff;
   end

   logic [63:0] neg_v;
   logic [63:0] m_sq;
   assign m_sq = {prod_ff[125:64], prod_ff[63:62]};
   assign neg_v = ({57'(7'd62 - e_ff), 7'd0} << (xpg_pkg::LOG_FRAC - 7)) - frac_ff;

   always_ff @(posedge clock) begin
      if (cmd_in.load_req) begin
         sel_ff <= req_sel;
         cmd_ff <= req_cmd;
      end
      if (cmd_in.draw) draw_ff <= draw_v;
      if (cmd_in.take_x) begin
         ax_ff <= absv;
         x_neg_ff <= ~u[31];
      end
      if (cmd_in.take_y) ay_ff <= absv;
      // ax^2 and ay^2 through the shared multiplier
      if (cmd_in.ax2_start) begin
         ma_ff <= {32'd0, ax_ff};
         mb_ff <= {32'd0, ax_ff};
         mcnt_ff <= '0;
         prod_ff <= '0;
      end
      if (cmd_in.ax2_step) begin
         ax2_ff <= sq[63:0];
         ma_ff <= {32'd0, ay_ff};
         mb_ff <= {32'd0, ay_ff};
      end
      if (cmd_in.ay2_step) acc_ff <= sq[63:0];
      if (cmd_in.form_r) begin
         r_ff <= ax2_ff + acc_ff;
         m_ff <= ax2_ff + acc_ff;
         e_ff <= 7'd62;
      end
      // normalize: shift left one bit a cycle until bit 62 is set
      if (cmd_in.norm_step && !m_ff[62] && m_ff != 0) begin
         m_ff <= m_ff << 1;
         e_ff <= e_ff - 7'd1;
      end
      if (cmd_in.log_init) frac_ff <= '0;
      if (cmd_in.mul_start) begin
         mcnt_ff <= '0;
         prod_ff <= '0;
         if (cmd_in.log_step) begin
            ma_ff <= m_ff;
            mb_ff <= m_ff;
         end else if (cmd_in.neg_form) begin
            ma_ff <= neg_v;
            mb_ff <= xpg_pkg::LN2_Q64;
         end else begin
            ma_ff <= lval_ff;
            mb_ff <= c_ff;
         end
      end
      if (cmd_in.mul_step) begin
         prod_ff <= prod_ff + sq;
         mcnt_ff <= mcnt_ff + 6'd1;
      end
      // one squaring of the log loop done
      if (cmd_in.log_step && !cmd_in.mul_start) begin
         frac_ff <= {frac_ff[62:0], m_sq[63]};
         m_ff <= m_sq[63] ? (m_sq >> 1) : m_sq;
      end
      if (cmd_in.neg_form && !cmd_in.mul_start) lval_ff <= prod_ff[126:63];
      // restoring division x^2 / r, one quotient bit a cycle
      if (cmd_in.div_init) begin
         c_ff <= (ax2_ff >= r_ff) ? 64'd1 : 64'd0;
         rem_ff <= (ax2_ff >= r_ff) ? ax2_ff - r_ff : ax2_ff;
      end
      if (cmd_in.div_step) begin
         if ({rem_ff, 1'b0} >= {1'b0, r_ff}) begin
            rem_ff <= 64'({rem_ff, 1'b0} - {1'b0, r_ff});
            c_ff <= {c_ff[62:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[62:0], 1'b0};
            c_ff <= {c_ff[62:0], 1'b0};
         end
      end
      if (cmd_in.z2_take) z2_ff <= 64'(prod_ff >> Z2_SHIFT);
      // bitwise square root, two bits of radicand a cycle
      if (cmd_in.sqrt_init) begin
         sq_v_ff <= z2_ff;
         sq_res_ff <= '0;
         sq_bit_ff <= 64'h4000000000000000;
      end
      if (cmd_in.sqrt_step) begin
         if (sq_bit_ff != 0) begin
            if (sq_v_ff >= sq_sum) begin
               sq_v_ff <= sq_v_ff - sq_sum;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
      end
   end

   // final rounding and sign
   logic [63:0] mag;
   assign mag = sq_res_ff + ((sq_v_ff > sq_res_ff) ? 64'd1 : 64'd0);

   always_ff @(posedge clock) begin
      if (cmd_in.finish_raw) begin
         raw_ff <= draw_ff;
         gauss_ff <= '0;
         tries_ff <= '0;
         gave_up_ff <= 1'b0;
      end
      if (cmd_in.finish_gauss) begin
         raw_ff <= '0;
         tries_ff <= tries_in;
         gave_up_ff <= 1'b0;
         if (x_neg_ff) begin
            gauss_ff <= (mag > 64'h80000000) ? 32'h80000000 : 32'(-mag);
         end else begin
            gauss_ff <= (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
         end
      end
      if (cmd_in.finish_giveup) begin
         raw_ff <= '0;
         gauss_ff <= '0;
         tries_ff <= 7'(MAX_TRIES);
         gave_up_ff <= 1'b1;
      end
   end

   logic [63:0] r_now;
   assign r_now = ax2_ff + acc_ff;
   assign status.cmd = cmd_ff;
   assign status.accept_pair = (r_now <= xpg_pkg::ONE_Q62) && (r_now != 0);
   assign status.norm_done = m_ff[62] || (m_ff == 0);
   assign status.mul_done = (mcnt_ff == 6'd3);
   assign raw_value = raw_ff;
   assign gauss_value = gauss_ff;
   assign tries = tries_ff;
   assign gave_up = gave_up_ff;

endmodule

// ----- rtl/xpg_control.sv -----
module xpg_control #(
   parameter int MAX_TRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  xpg_pkg::dp_status_type status,
   output xpg_pkg::dp_cmd_type    cmd_out,
   output logic [6:0]             tries_out
);

   localparam logic [4:0] S_IDLE = 5'd0, S_DRAWX = 5'd1, S_DRAWY = 5'd2,
      S_SQX = 5'd3, S_SQY = 5'd4, S_CHECK = 5'd5, S_NORM = 5'd6,
      S_LOGLD = 5'd7, S_LOGMUL = 5'd8, S_LOGUPD = 5'd9, S_NEGLD = 5'd10,
      S_NEGMUL = 5'd11, S_NEGUPD = 5'd12, S_DIV = 5'd13, S_ZLD = 5'd14,
      S_ZMUL = 5'd15, S_ZTAKE = 5'd16, S_SQRT = 5'd17, S_OUT = 5'd18,
      S_RAW = 5'd19, S_DONE = 5'd20, S_GIVEUP = 5'd21, S_XLD = 5'd22;

   logic [4:0] state_ff, state_in;
   logic [6:0] tries_ff, tries_in;
   logic [6:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // the output registers may be written once the held word is gone
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      tries_in = tries_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_out = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd_out.load_req = 1'b1;
            if (req_valid) begin
               tries_in = '0;
               state_in = S_XLD;
            end
         end
         S_XLD: begin
            cmd_out.draw = 1'b1;
            if (status.cmd == xpg_pkg::CMD_RAW) begin
               state_in = S_RAW;
            end else begin
               cmd_out.take_x = 1'b1;
               state_in = S_DRAWY;
            end
         end
         S_RAW: begin
            if (out_free) begin
               cmd_out.finish_raw = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DRAWX: begin
            cmd_out.draw = 1'b1;
            cmd_out.take_x = 1'b1;
            state_in = S_DRAWY;
         end
         S_DRAWY: begin
            cmd_out.draw = 1'b1;
            cmd_out.take_y = 1'b1;
            tries_in = tries_ff + 7'd1;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd_out.ax2_start = 1'b1;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd_out.ax2_step = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd_out.ay2_step = 1'b1;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (cnt_ff == 7'd0) begin
               if (status.accept_pair) begin
                  cmd_out.form_r = 1'b1;
                  cnt_in = 7'd1;
               end else if (tries_ff == 7'(MAX_TRIES)) begin
                  state_in = S_GIVEUP;
               end else begin
                  state_in = S_DRAWX;
               end
            end else begin
               cmd_out.norm_step = 1'b1;
               if (status.norm_done) begin
                  cmd_out.log_init = 1'b1;
                  cnt_in = '0;
                  state_in = S_LOGLD;
               end
            end
         end
         S_LOGLD: begin
            cmd_out.mul_start = 1'b1;
            cmd_out.log_step = 1'b1;
            state_in = S_LOGMUL;
         end
         S_LOGMUL: begin
            cmd_out.mul_step = 1'b1;
            if (status.mul_done) state_in = S_LOGUPD;
         end
         S_LOGUPD: begin
            cmd_out.log_step = 1'b1;
            cnt_in = cnt_ff + 7'd1;
            state_in = (cnt_ff == 7'(xpg_pkg::LOG_FRAC - 1)) ? S_NEGLD : S_LOGLD;
         end
         S_NEGLD: begin
            cmd_out.mul_start = 1'b1;
            cmd_out.neg_form = 1'b1;
            state_in = S_NEGMUL;
         end
         S_NEGMUL: begin
            cmd_out.mul_step = 1'b1;
            if (status.mul_done) state_in = S_NEGUPD;
         end
         S_NEGUPD: begin
            cmd_out.neg_form = 1'b1;
            cmd_out.div_init = 1'b1;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd_out.div_step = 1'b1;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd61) state_in = S_ZLD;
         end
         S_ZLD: begin
            cmd_out.mul_start = 1'b1;
            state_in = S_ZMUL;
         end
         S_ZMUL: begin
            cmd_out.mul_step = 1'b1;
            if (status.mul_done) state_in = S_ZTAKE;
         end
         S_ZTAKE: begin
            cmd_out.z2_take = 1'b1;
            state_in = S_SQRT;
            cnt_in = '0;
         end
         S_SQRT: begin
            if (cnt_ff == 7'd0) begin
               cmd_out.sqrt_init = 1'b1;
            end else begin
               cmd_out.sqrt_step = 1'b1;
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd32) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd_out.finish_gauss = 1'b1;
               cnt_in = '0;
               state_in = S_DONE;
            end
         end
         S_GIVEUP: begin
            if (out_free) begin
               cmd_out.finish_giveup = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            cnt_in = '0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tries_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tries_ff <= tries_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign tries_out = tries_ff;

endmodule

// ----- rtl/xorshift_polar_gaussian_source.sv -----
// Gaussian noise source over independent xorshift64 streams.
// Input channel req_: req_cmd (0 raw draw, 1 gaussian) and req_stream, taken
// with req_valid/req_ready. Result channel rsp_: raw_value, gauss_value, tries,
// gave_up under rsp_valid/rsp_ready; one result per request.
// csr_write/csr_index/csr_data load a seed and reload that stream at once.
// Requests are worked one at a time. A gaussian examines pairs until one is
// accepted; the time for the accepted one varies with the one-bit-a-cycle
// normalization of r. It then runs 56 log squarings through the shared
// 64x64 multiplier (four 32x32 partial products, one a cycle), a restoring
// divider and a bitwise square root, all sequenced one item at a time.
// A give-up at the try cap raises rsp_valid once MAX_TRIES pairs have been
// rejected. req_ready returns in the same cycle that rsp_valid rises.
// Reset (synchronous) loads streams with 1, 2, 3, 4 and empties the output.
// A stalled receiver holds the result; the next request is still taken and
// worked on, and its result waits in the last step until the held word goes.
module xorshift_polar_gaussian_source #(
   parameter int NUM_STREAMS = 4,
   parameter int MAX_TRIES = 64,
   parameter int OUT_FRAC_BITS = 26
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [1:0]  req_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_raw_value,
   output logic signed [31:0] rsp_gauss_value,
   output logic [6:0]  rsp_tries,
   output logic        rsp_gave_up
);

   xpg_pkg::dp_cmd_type cmd;
   xpg_pkg::dp_status_type status;
   logic [6:0] tries_cnt;
   logic [31:0] gauss;

   xpg_control #(.MAX_TRIES(MAX_TRIES)) u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd_out(cmd), .tries_out(tries_cnt)
   );

   xpg_datapath #(
      .NUM_STREAMS(NUM_STREAMS), .OUT_FRAC_BITS(OUT_FRAC_BITS), .MAX_TRIES(MAX_TRIES)
   ) u_datapath (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_cmd(req_cmd), .req_stream(req_stream),
      .cmd_in(cmd), .tries_in(tries_cnt), .status(status),
      .raw_value(rsp_raw_value), .gauss_value(gauss),
      .tries(rsp_tries), .gave_up(rsp_gave_up)
   );

   assign rsp_gauss_value = gauss;

endmodule

// ----- bench/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_STREAMS = 4;
   localparam int MAX_TRIES = 64;
   localparam int OUT_FRAC_BITS = 26;

   // seed register indexes
   localparam logic [1:0] REG_SEED0 = 2'd0;
   localparam logic [1:0] REG_SEED1 = 2'd1;
   localparam logic [1:0] REG_SEED2 = 2'd2;
   localparam logic [1:0] REG_SEED3 = 2'd3;

   typedef struct {
      logic [63:0] raw_value;
      logic [31:0] gauss_value;
      logic [6:0]  tries;
      logic        gave_up;
   } noise_word_type;

   class noise_scoreboard_type;
      logic [63:0]     stream_state [NUM_STREAMS];
      noise_word_type  pending_words [$];
      int              errors;

      function new();
         errors = 0;
         for (int i = 0; i < NUM_STREAMS; i++)
            stream_state[i] = 64'(i + 1);
      endfunction

      function void load_seed(logic [1:0] index, logic [63:0] value);
         if (index < NUM_STREAMS)
            stream_state[index] = value;
      endfunction

      function logic [63:0] advance(int s);
         logic [63:0] v;
         v = stream_state[s];
         v ^= v << 21;
         v ^= v >> 35;
         v ^= v << 4;
         stream_state[s] = v;
         return v;
      endfunction

      function logic [63:0] root_round(logic [63:0] n);
         logic [63:0] v, res, bit_w;
         v = n;
         res = 0;
         bit_w = 64'd1 << 62;
         while (bit_w > v)
            bit_w >>= 2;
         while (bit_w != 0) begin
            if (v >= res + bit_w) begin
               v -= res + bit_w;
               res = (res >> 1) + bit_w;
            end else begin
               res >>= 1;
            end
            bit_w >>= 2;
         end
         if (n - res * res > res)
            res++;
         return res;
      endfunction

      // |z| = sqrt(-2 ln r / r) * |x| in fixed point
      function logic [63:0] magnitude(logic [63:0] r, logic [63:0] ax2);
         int unsigned e;
         logic [63:0]  m, frac, neg, lval, c, rem, z2;
         logic [127:0] p;
         e = 0;
         while (e < 63 && (r >> (e + 1)) != 0)
            e++;
         m = r << (62 - e);
         frac = 0;
         for (int i = 0; i < xpg_pkg::LOG_FRAC; i++) begin
            p = {64'd0, m} * {64'd0, m};
            m = p[125:62];
            frac <<= 1;
            if (m[63]) begin
               frac |= 1;
               m >>= 1;
            end
         end
         neg = (64'(62 - e) << xpg_pkg::LOG_FRAC) - frac;
         p = {64'd0, neg} * {64'd0, xpg_pkg::LN2_Q64};
         lval = p[126:63];
         c = (ax2 >= r) ? 64'd1 : 64'd0;
         rem = ax2 - c * r;
         for (int i = 0; i < 62; i++) begin
            rem <<= 1;
            c <<= 1;
            if (rem >= r) begin
               rem -= r;
               c |= 1;
            end
         end
         p = {64'd0, lval} * {64'd0, c};
         p = p >> (118 - 2 * OUT_FRAC_BITS);
         z2 = p[63:0];
         return root_round(z2);
      endfunction

      // compute the word an accepted request must produce
      function void note_request(logic cmd, logic [1:0] stream);
         noise_word_type w;
         int s;
         logic done;
         logic signed [63:0] x, y;
         logic [63:0] ax, ay, ax2, r, mag;
         s = stream % NUM_STREAMS;
         w = '{raw_value: 64'd0, gauss_value: 32'd0, tries: 7'd0, gave_up: 1'b0};
         if (cmd == xpg_pkg::CMD_RAW) begin
            w.raw_value = advance(s);
         end else begin
            done = 0;
            while (!done && w.tries < MAX_TRIES) begin
               x = $signed(advance(s) >> 32) - 64'sd2147483648;
               y = $signed(advance(s) >> 32) - 64'sd2147483648;
               ax = (x < 0) ? -x : x;
               ay = (y < 0) ? -y : y;
               ax2 = ax * ax;
               r = ax2 + ay * ay;
               w.tries++;
               if (r <= xpg_pkg::ONE_Q62 && r != 0) begin
                  mag = magnitude(r, ax2);
                  if (x < 0)
                     w.gauss_value = (mag > 64'd2147483648) ? 32'h80000000 : 32'(-mag);
                  else
                     w.gauss_value = (mag > 64'd2147483647) ? 32'h7fffffff : mag[31:0];
                  done = 1;
               end
            end
            if (!done)
               w.gave_up = 1;
         end
         pending_words.push_back(w);
      endfunction

      function void check_result(logic [63:0] raw, logic [31:0] gauss, logic [6:0] tries,
                                 logic gave_up);
         noise_word_type w;
         if (pending_words.size() == 0) begin
            $error("unexpected result word raw=%h gauss=%h", raw, gauss);
            errors++;
            return;
         end
         w = pending_words.pop_front();
         if (raw !== w.raw_value) begin
            $error("raw_value expected %h actual %h", w.raw_value, raw);
            errors++;
         end
         if (gauss !== w.gauss_value) begin
            $error("gauss_value expected %h actual %h", w.gauss_value, gauss);
            errors++;
         end
         if (tries !== w.tries) begin
            $error("tries expected %0d actual %0d", w.tries, tries);
            errors++;
         end
         if (gave_up !== w.gave_up) begin
            $error("gave_up expected %0d actual %0d", w.gave_up, gave_up);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [1:0]  csr_index = 0;
   logic [63:0] csr_data = 0;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_cmd = 0;
   logic [1:0]  req_stream = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_raw_value;
   logic signed [31:0] rsp_gauss_value;
   logic [6:0]  rsp_tries;
   logic        rsp_gave_up;

   logic                 steady = 0;
   noise_scoreboard_type sb = new();

   xorshift_polar_gaussian_source dut (.*);

   always #5 clock = ~clock;

   // drain result words with random stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_raw_value, rsp_gauss_value, rsp_tries, rsp_gave_up);
      rsp_ready <= steady || ($urandom_range(99) >= 31);
   end

   task automatic send_request(logic cmd, logic [1:0] stream);
      if (!steady && $urandom_range(99) < 31) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < 31);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_stream <= stream;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(cmd, stream);
   endtask

   // hold until every word has come back, with the request line low
   task automatic drain;
      req_valid <= 0;
      while (sb.pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_seed(logic [1:0] index, logic [63:0] value);
      csr_write <= 1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      sb.load_seed(index, value);
   endtask

   task automatic load_seeds(logic [63:0] s0, s1, s2, s3);
      drain();
      @(posedge clock);
      write_seed(REG_SEED0, s0);
      write_seed(REG_SEED1, s1);
      write_seed(REG_SEED2, s2);
      write_seed(REG_SEED3, s3);
      csr_write <= 0;
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++)
         send_request(($urandom_range(99) < 40) ? xpg_pkg::CMD_GAUSS : xpg_pkg::CMD_RAW,
                      2'($urandom_range(3)));
   endtask

   function automatic logic [63:0] rand_seed();
      return {$urandom, $urandom};
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset seeds, every stream and command
      for (int s = 0; s < NUM_STREAMS; s++) begin
         send_request(xpg_pkg::CMD_RAW, 2'(s));
         send_request(xpg_pkg::CMD_GAUSS, 2'(s));
      end
      // zero seed stays zero, gaussian gives up; all-ones, one and top-bit seeds on the others
      load_seeds(64'hffffffffffffffff, 64'd1, 64'd0, 64'h8000000000000000);
      send_request(xpg_pkg::CMD_RAW, 2'd2);
      send_request(xpg_pkg::CMD_GAUSS, 2'd2);
      for (int s = 0; s < NUM_STREAMS; s++) begin
         send_request(xpg_pkg::CMD_GAUSS, 2'(s));
         send_request(xpg_pkg::CMD_RAW, 2'(s));
      end
      send_request(xpg_pkg::CMD_GAUSS, 2'd0);
      send_request(xpg_pkg::CMD_GAUSS, 2'd3);

      // random phases over several seed settings
      load_seeds(rand_seed(), rand_seed(), rand_seed(), rand_seed());
      random_phase(200);
      steady = 1;
      load_seeds(rand_seed(), rand_seed(), rand_seed(), rand_seed());
      random_phase(150);
      steady = 0;
      load_seeds(64'hffffffffffffffff, 64'd1, rand_seed(), 64'hfffffffffffffffe);
      random_phase(200);
      load_seeds(rand_seed(), rand_seed(), 64'd0, rand_seed());
      random_phase(60);
      load_seeds(rand_seed(), rand_seed(), rand_seed(), rand_seed());
      random_phase(290);

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending_words.size() == 0) begin
         $display("xorshift_polar_gaussian_source test passed");
      end else begin
         $display("xorshift_polar_gaussian_source test failed");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("xorshift_polar_gaussian_source test failed");
      $finish;
   end
endmodule
